// ===== rtl/core/rar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants for the rational arithmetic reduce block.
// ----------------------------------------------------------------------------
package rar_pkg;

	// operand field width, magnitude width of products and sums
	localparam int OP_W  = 16;
	localparam int MAG_W = 2 * OP_W;
	localparam int NUM_W = 33;
	localparam int DEN_W = 31;
	localparam int K_W   = $clog2(MAG_W + 1);

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_ALIGN,
		ST_GCD,
		ST_DIV_NUM,
		ST_DIV_DEN,
		ST_OUT
	} state_t;

	typedef struct packed {
		mode_t                  mode;
		logic signed [OP_W-1:0] a_num;
		logic signed [OP_W-1:0] a_den;
		logic signed [OP_W-1:0] b_num;
		logic signed [OP_W-1:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] res_num;
		logic [DEN_W-1:0]        res_den;
		logic                    status;
	} rsp_t;

endpackage

// ===== rtl/core/rational_arith_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result to lowest terms with a binary gcd and a serial divider.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   rar_pkg::req_t
//   rsp      out  rsp_valid/rsp_stall   rar_pkg::rsp_t
//
// One beat at a time: two or three products on the shared multiplier, a sum
// step, removal of common twos, binary gcd steps, then two divisions by the
// gcd, one cycle per bit.
// Zero denominators and zero numerators skip the gcd and the divisions.
// req_stall is high from accept until the result beat is taken.
// Reset returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module rational_arith_reduce (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rar_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rar_pkg::rsp_t rsp
);

	localparam int OW = rar_pkg::OP_W;
	localparam int MW = rar_pkg::MAG_W;
	localparam int NW = rar_pkg::NUM_W;
	localparam int DW = rar_pkg::DEN_W;
	localparam int KW = rar_pkg::K_W;

	rar_pkg::state_t state_q, state_d;

	rar_pkg::mode_t mode_q;
	logic [OW-1:0]  an_q, ad_q, bn_q, bd_q;
	logic           an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [1:0]     step_q;
	logic [MW-1:0]  p_mag_q [3];
	logic           p_neg_q [3];
	logic [MW-1:0]  num_q, den_q, x_q, y_q, g_q, nm_q;
	logic           neg_q;
	logic [KW-1:0]  k_q;
	rar_pkg::rsp_t  rsp_q;
	logic           rsp_valid_q;

	logic          accept;
	logic          den_zero_in;
	logic [OW-1:0] an_mag, ad_mag, bn_mag, bd_mag;
	logic [OW-1:0] mul_x, mul_y;
	logic          mul_xs, mul_ys;
	logic [MW-1:0] prod;
	logic          last_step;
	logic [MW-1:0] t_mag, sum_mag, den_mag;
	logic          t_neg, sum_neg, den_neg;
	logic [MW-1:0] gdiff;
	logic [MW-1:0] g_comb;
	logic          div_start;
	logic [MW-1:0] div_dividend, div_divisor, div_quo;
	logic          div_done;
	logic [NW-1:0] num_ext;

	// operand magnitudes
	assign an_mag = req.a_num[OW-1] ? OW'(-req.a_num) : OW'(req.a_num);
	assign ad_mag = req.a_den[OW-1] ? OW'(-req.a_den) : OW'(req.a_den);
	assign bn_mag = req.b_num[OW-1] ? OW'(-req.b_num) : OW'(req.b_num);
	assign bd_mag = req.b_den[OW-1] ? OW'(-req.b_den) : OW'(req.b_den);
	assign den_zero_in = (ad_mag == '0) || (bd_mag == '0);

	assign accept = req_valid && !req_stall;

	// shared multiplier operand select
	always_comb begin
		mul_x  = (step_q == 2'd0) ? an_q : ad_q;
		mul_xs = (step_q == 2'd0) ? an_neg_q : ad_neg_q;
		if (step_q == 2'd2) begin
			mul_y  = bd_q;
			mul_ys = bd_neg_q;
		end else if ((step_q == 2'd0) == (mode_q == rar_pkg::MODE_MUL)) begin
			mul_y  = bn_q;
			mul_ys = bn_neg_q;
		end else begin
			mul_y  = bd_q;
			mul_ys = bd_neg_q;
		end
	end
	assign prod = MW'(mul_x) * MW'(mul_y);
	assign last_step = (mode_q == rar_pkg::MODE_MUL || mode_q == rar_pkg::MODE_DIV) ?
		(step_q == 2'd1) : (step_q == 2'd2);

	// signed magnitude sum of the cross products for add and subtract; multiply and divide pass the first product through
	always_comb begin
		t_mag   = p_mag_q[1];
		t_neg   = p_neg_q[1] ^ ((mode_q == rar_pkg::MODE_SUB) && (p_mag_q[1] != '0));
		sum_mag = p_mag_q[0];
		sum_neg = p_neg_q[0];
		den_mag = p_mag_q[1];
		den_neg = p_neg_q[1];
		if (mode_q == rar_pkg::MODE_ADD || mode_q == rar_pkg::MODE_SUB) begin
			den_mag = p_mag_q[2];
			den_neg = p_neg_q[2];
			if (p_neg_q[0] == t_neg) begin
				sum_mag = p_mag_q[0] + t_mag;
				sum_neg = p_neg_q[0];
			end else if (p_mag_q[0] >= t_mag) begin
				sum_mag = p_mag_q[0] - t_mag;
				sum_neg = p_neg_q[0];
			end else begin
				sum_mag = t_mag - p_mag_q[0];
				sum_neg = t_neg;
			end
			if (sum_mag == '0) begin
				sum_neg = 1'b0;
			end
		end
	end

	// gcd step unit: compare and subtract, and gcd with common twos restored
	assign gdiff  = (x_q > y_q) ? (x_q - y_q) : (y_q - x_q);
	assign g_comb = x_q << k_q;

	// divider feed: numerator first, then denominator
	assign div_start    = ((state_q == rar_pkg::ST_GCD) && (x_q == y_q)) ||
		((state_q == rar_pkg::ST_DIV_NUM) && div_done);
	assign div_dividend = (state_q == rar_pkg::ST_GCD) ? num_q : den_q;
	assign div_divisor  = (state_q == rar_pkg::ST_GCD) ? g_comb : g_q;

	rar_div #(
		.WIDTH(MW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done)
	);

	assign num_ext = NW'(nm_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rar_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			rar_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = den_zero_in ? rar_pkg::ST_OUT : rar_pkg::ST_MUL;
				end
			end
			rar_pkg::ST_MUL: begin
				if (last_step) begin
					state_d = rar_pkg::ST_SUM;
				end
			end
			rar_pkg::ST_SUM: begin
				if (den_mag == '0 || sum_mag == '0) begin
					state_d = rar_pkg::ST_OUT;
				end else begin
					state_d = rar_pkg::ST_ALIGN;
				end
			end
			rar_pkg::ST_ALIGN: begin
				if (x_q[0] || y_q[0]) begin
					state_d = rar_pkg::ST_GCD;
				end
			end
			rar_pkg::ST_GCD: begin
				if (x_q == y_q) begin
					state_d = rar_pkg::ST_DIV_NUM;
				end
			end
			rar_pkg::ST_DIV_NUM: begin
				if (div_done) begin
					state_d = rar_pkg::ST_DIV_DEN;
				end
			end
			rar_pkg::ST_DIV_DEN: begin
				if (div_done) begin
					state_d = rar_pkg::ST_OUT;
				end
			end
			rar_pkg::ST_OUT: begin
				if (!rsp_stall) begin
					state_d = rar_pkg::ST_IDLE;
				end
			end
			default: state_d = rar_pkg::ST_IDLE;
		endcase
	end

	// result valid flag and multiplier step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (state_d == rar_pkg::ST_OUT && state_q != rar_pkg::ST_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == rar_pkg::ST_MUL && !last_step) begin
				step_q <= step_q + 2'd1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			rar_pkg::ST_IDLE: begin
				if (accept) begin
					mode_q   <= req.mode;
					an_q     <= an_mag;
					ad_q     <= ad_mag;
					bn_q     <= bn_mag;
					bd_q     <= bd_mag;
					an_neg_q <= req.a_num[OW-1];
					ad_neg_q <= req.a_den[OW-1];
					bn_neg_q <= req.b_num[OW-1];
					bd_neg_q <= req.b_den[OW-1];
					rsp_q    <= '{res_num: '0, res_den: '0, status: 1'b1};
				end
			end
			rar_pkg::ST_MUL: begin
				p_mag_q[step_q] <= prod;
				p_neg_q[step_q] <= (mul_xs ^ mul_ys) && (prod != '0);
			end
			rar_pkg::ST_SUM: begin
				num_q <= sum_mag;
				den_q <= den_mag;
				x_q   <= sum_mag;
				y_q   <= den_mag;
				neg_q <= sum_neg ^ den_neg;
				k_q   <= '0;
				if (den_mag == '0) begin
					rsp_q <= '{res_num: '0, res_den: '0, status: 1'b1};
				end else begin
					rsp_q <= '{res_num: '0, res_den: DW'(1), status: 1'b0};
				end
			end
			rar_pkg::ST_ALIGN: begin
				if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end
			end
			rar_pkg::ST_GCD: begin
				if (x_q == y_q) begin
					g_q <= g_comb;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q > y_q) begin
					x_q <= gdiff >> 1;
				end else begin
					y_q <= gdiff >> 1;
				end
			end
			rar_pkg::ST_DIV_NUM: begin
				if (div_done) begin
					nm_q <= div_quo;
				end
			end
			rar_pkg::ST_DIV_DEN: begin
				if (div_done) begin
					rsp_q.res_num <= neg_q ? -num_ext : num_ext;
					rsp_q.res_den <= DW'(div_quo);
					rsp_q.status  <= 1'b0;
				end
			end
			rar_pkg::ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// one result beat per item, then the beat is gone
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall |=> !rsp_valid)
		else $error("result beat repeated");

	// no new item while one is in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input taken while busy");

	// an ok result always has a nonzero denominator
	a_den_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.status |-> rsp.res_den != '0)
		else $error("zero denominator with ok status");

	// an error result is all zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.res_num == '0 && rsp.res_den == '0)
		else $error("error result not cleared");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == rar_pkg::ST_DIV_NUM || state_q == rar_pkg::ST_DIV_DEN)
		else $error("divider done out of sequence");

endmodule

// ===== rtl/core/rar_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rar_div #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] quotient,
	output logic             done
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   trial;

	// trial subtract of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	// datapath: remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[WIDTH]) begin
				rem_q <= trial[WIDTH-1:0];
			end else begin
				rem_q <= shifted[WIDTH-1:0];
			end
			quo_q <= {quo_q[WIDTH-2:0], ~trial[WIDTH]};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== dv/tb_rational_arith_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arith_reduce
// Drives fraction add/sub/mul/div beats with random gaps and output stalls,
// predicts the reduced fraction for each accepted beat and checks every
// result beat against it in order.
// ----------------------------------------------------------------------------
module tb_rational_arith_reduce;

	localparam int N_RANDOM = 1700;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	rar_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	rar_pkg::rsp_t rsp;

	rar_pkg::req_t pending_q[$];
	rar_pkg::rsp_t fraction_q[$];
	int            n_mismatch = 0;
	bit            stim_done = 1'b0;
	int            cyc;

	rational_arith_reduce dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// gcd by remainders
	function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// reduced fraction for one operation
	function automatic rar_pkg::rsp_t reduce_fraction(rar_pkg::req_t r);
		longint an, ad, bn, bd, n, d, g;
		rar_pkg::rsp_t o;
		an = r.a_num; ad = r.a_den; bn = r.b_num; bd = r.b_den;
		o = '0;
		if (ad == 0 || bd == 0) begin
			o.status = 1'b1;
			return o;
		end
		case (r.mode)
			rar_pkg::MODE_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
			rar_pkg::MODE_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
			rar_pkg::MODE_MUL: begin n = an * bn; d = ad * bd; end
			default: begin n = an * bd; d = ad * bn; end
		endcase
		if (d == 0) begin
			o.status = 1'b1;
			return o;
		end
		if (n == 0) begin
			o.res_den = rar_pkg::DEN_W'(1);
			return o;
		end
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		g = longint'(gcd_of(longint'(n < 0 ? -n : n), d));
		o.res_num = rar_pkg::NUM_W'(n / g);
		o.res_den = rar_pkg::DEN_W'(d / g);
		return o;
	endfunction

	function automatic logic [rar_pkg::OP_W-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return rar_pkg::OP_W'($urandom_range(0, 8)) - 16'd4;
			4, 5: return rar_pkg::OP_W'($urandom_range(0, 64)) *
				(($urandom & 1) ? 16'hffff : 16'd1);
			default: return rar_pkg::OP_W'($urandom);
		endcase
	endfunction

	// stimulus: directed corners, then random beats
	initial begin
		rar_pkg::req_t r;
		int   k;
		logic [rar_pkg::OP_W-1:0] ext[4];
		ext = '{16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff};
		for (k = 0; k < 4; k++) begin
			r.mode = rar_pkg::mode_t'(k);
			r.a_num = ext[k]; r.a_den = ext[(k + 1) % 4];
			r.b_num = ext[(k + 2) % 4]; r.b_den = ext[(k + 3) % 4];
			pending_q.push_back(r);
			r.a_num = 16'sh8000; r.a_den = 16'sh8000; r.b_num = 16'sh8000;
			r.b_den = 16'sh7fff;
			pending_q.push_back(r);
		end
		// zero operand denominators
		r = '{rar_pkg::MODE_ADD, 16'sd3, 16'sd0, 16'sd5, 16'sd7};
		pending_q.push_back(r);
		r = '{rar_pkg::MODE_MUL, 16'sd3, 16'sd5, 16'sd5, 16'sd0};
		pending_q.push_back(r);
		// zero result denominator on divide
		r = '{rar_pkg::MODE_DIV, 16'sd3, 16'sd5, 16'sd0, 16'sd7};
		pending_q.push_back(r);
		// zero numerators
		r = '{rar_pkg::MODE_SUB, 16'sd2, 16'sd4, 16'sd1, 16'sd2};
		pending_q.push_back(r);
		r = '{rar_pkg::MODE_MUL, 16'sd0, -16'sd4, 16'sd9, 16'sd2};
		pending_q.push_back(r);
		// negative denominators
		r = '{rar_pkg::MODE_ADD, 16'sd1, -16'sd6, 16'sd1, -16'sd3};
		pending_q.push_back(r);
		r = '{rar_pkg::MODE_DIV, -16'sd6, 16'sd4, -16'sd9, -16'sd8};
		pending_q.push_back(r);
		for (k = 0; k < N_RANDOM; k++) begin
			r.mode = rar_pkg::mode_t'($urandom_range(0, 3));
			r.a_num = pick_operand(); r.a_den = pick_operand();
			r.b_num = pick_operand(); r.b_den = pick_operand();
			pending_q.push_back(r);
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				fraction_q.push_back(reduce_fraction(req));
			if (pending_q.size() != 0 && (cyc < 30000 || $urandom_range(0, 99) >= 6)) begin
				req_valid <= 1'b1;
				req <= pending_q.pop_front();
			end else begin
				req_valid <= 1'b0;
				if (pending_q.size() == 0)
					stim_done <= 1'b1;
			end
		end
	end

	// monitor and output stalls
	always @(posedge clk or negedge arst_n) begin
		rar_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			rsp_stall <= (cyc >= 30000 && cyc < 60000) ? 1'b0 : ($urandom_range(0, 99) < 6);
			if (rsp_valid && !rsp_stall) begin
				if (fraction_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected result beat %h", rsp);
				end else begin
					want = fraction_q.pop_front();
					if (rsp.res_num !== want.res_num || rsp.res_den !== want.res_den ||
							rsp.status !== want.status) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("mismatch: num %0d/%0d den %0d/%0d st %0b/%0b (exp/act)",
								want.res_num, rsp.res_num, want.res_den, rsp.res_den,
								want.status, rsp.status);
					end
				end
			end
		end
	end

	// reset and end of run
	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && !req_valid && fraction_q.size() == 0);
		repeat (300) @(posedge clk);
		if (n_mismatch == 0 && fraction_q.size() == 0)
			$display("[rational_arith_reduce] OK");
		else
			$display("[rational_arith_reduce] ERROR");
		$finish;
	end

	// timeout
	initial begin
		#3000000;
		$display("[rational_arith_reduce] ERROR");
		$finish;
	end

endmodule
